/* hdl/arpc_pkg.sv */
// Shared types and constants for the ARP cache table.
// Holds operation and status codes, field widths, the controller state
// and the result record passed from the controller to the output stage.
package arpc_pkg;

   localparam int IP_W        = 32;
   localparam int DATA_W      = 48;
   localparam int SLOT_W      = 4;
   localparam int COUNT_W     = 5;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 96;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_READ   = 2'd2,
      MODE_DELETE = 2'd3
   } arpc_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_RANGE = 2'd3
   } arpc_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_COPY,
      S_FETCH,
      S_RESP
   } arpc_state_type;

   typedef struct packed {
      arpc_status_type     status;
      logic [IP_W-1:0]     found_ip;
      logic [DATA_W-1:0]   found_data;
      logic [SLOT_W-1:0]   found_slot;
      logic [COUNT_W-1:0]  entry_count;
   } arpc_result_type;

endpackage

/* hdl/arpc_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module arpc_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/arpc_ctrl.sv */
// Operation sequencer for the ARP cache table: scans, appends, reads and
// compacts entries held in the table RAM, and keeps the entry count.
// Depends on arpc_pkg; drives one arpc_ram instance through the top level.
module arpc_ctrl
   import arpc_pkg::*;
#(
   parameter int TABLE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [MODE_W-1:0]             req_mode,
   input  logic [IP_W-1:0]               req_ip,
   input  logic [DATA_W-1:0]             req_data,
   input  logic [SLOT_W-1:0]             req_slot,
   output logic                          res_valid,
   input  logic                          res_ready,
   output arpc_result_type               res,
   output logic                          ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_wr_addr,
   output logic [IP_W+PAYLOAD_BITS-1:0]  ram_wr_data,
   output logic                          ram_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_rd_addr,
   input  logic [IP_W+PAYLOAD_BITS-1:0]  ram_rd_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   arpc_state_type          state_ff, state_in;
   arpc_mode_type           mode_ff, mode_in;
   logic [IP_W-1:0]         key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] data_ff, data_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   arpc_result_type         res_ff, res_in;

   logic [IP_W-1:0]         rd_key;
   logic [PAYLOAD_BITS-1:0] rd_payload;
   logic                    slot_ok;
   logic                    scan_last;
   logic                    copy_last;

   // RAM word layout: payload above key.
   assign rd_key     = ram_rd_data[IP_W-1:0];
   assign rd_payload = ram_rd_data[IP_W+PAYLOAD_BITS-1:IP_W];

   assign slot_ok   = 32'(req_slot) < 32'(count_ff);
   assign scan_last = (32'(idx_ff) + 32'd1) == 32'(count_ff);
   assign copy_last = (32'(idx_ff) + 32'd2) == 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      key_ff  <= key_in;
      data_ff <= data_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      data_in     = data_ff;
      slot_in     = slot_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      res_in      = res_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = {data_ff, key_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in = arpc_mode_type'(req_mode);
               key_in  = req_ip;
               data_in = PAYLOAD_BITS'(req_data);
               slot_in = IDX_W'(req_slot);
               idx_in  = '0;
               res_in  = '0;
               unique case (arpc_mode_type'(req_mode))
                  MODE_INSERT: begin
                     if (count_ff == '0) begin
                        // Empty table: append at slot zero right away.
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = {PAYLOAD_BITS'(req_data), req_ip};
                        count_in    = CNT_W'(1);
                        state_in    = S_RESP;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  MODE_LOOKUP: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_MISS;
                        state_in      = S_RESP;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  MODE_READ: begin
                     if (slot_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(req_slot);
                        state_in    = S_FETCH;
                     end else begin
                        res_in.status = ST_RANGE;
                        state_in      = S_RESP;
                     end
                  end
                  MODE_DELETE: begin
                     if (!slot_ok) begin
                        res_in.status = ST_RANGE;
                        state_in      = S_RESP;
                     end else if ((32'(req_slot) + 32'd1) == 32'(count_ff)) begin
                        // Last entry: nothing to move down.
                        res_in.found_slot = req_slot;
                        count_in          = count_ff - 1'b1;
                        state_in          = S_RESP;
                     end else begin
                        idx_in      = IDX_W'(req_slot);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(req_slot) + 1'b1;
                        state_in    = S_COPY;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_SCAN: begin
            // RAM data holds the entry at idx_ff; prefetch the next one.
            if (rd_key == key_ff) begin
               res_in.found_slot = SLOT_W'(idx_ff);
               if (mode_ff == MODE_INSERT) begin
                  ram_wr_en = 1'b1;
               end else begin
                  res_in.found_ip   = rd_key;
                  res_in.found_data = DATA_W'(rd_payload);
               end
               state_in = S_RESP;
            end else if (scan_last) begin
               if (mode_ff == MODE_LOOKUP) begin
                  res_in.status = ST_MISS;
               end else if (32'(count_ff) < 32'(TABLE_DEPTH)) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_addr       = IDX_W'(count_ff);
                  res_in.found_slot = SLOT_W'(count_ff);
                  count_in          = count_ff + 1'b1;
               end else begin
                  res_in.status = ST_FULL;
               end
               state_in = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
         end

         S_COPY: begin
            // Move entry idx_ff+1 down to idx_ff; the read of idx_ff+2 never
            // hits the slot being written, so no forwarding is needed.
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            if (copy_last) begin
               res_in.found_slot = SLOT_W'(slot_ff);
               count_in          = count_ff - 1'b1;
               state_in          = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + IDX_W'(2);
               idx_in      = idx_ff + 1'b1;
            end
         end

         S_FETCH: begin
            res_in.found_ip   = rd_key;
            res_in.found_data = DATA_W'(rd_payload);
            res_in.found_slot = SLOT_W'(slot_ff);
            state_in          = S_RESP;
         end

         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      res             = res_ff;
      res.entry_count = COUNT_W'(count_ff);
   end

endmodule

/* hdl/arp_cache_table_top.sv */
// ARP cache table: insert, lookup, read and delete over a compacted table.
// Out-of-range read or delete, delete of the last entry and ops on an empty table
// go straight to the response; an in-range read fetches its entry first;
// lookup/insert scan the table RAM one entry a cycle, stopping at a hit or after
// the last entry; delete moves each later entry down one slot, one entry a cycle.
// One item in work at a time; the next is taken once its result
// sits in the output register. Reset clears the count; no RAM clearing pass.
module arp_cache_table_top
   import arpc_pkg::*;
#(
   parameter int TABLE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] ip_addr, [79:32] entry_data, [83:80] slot, [87:84] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [MODE_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] found_ip, [79:32] found_data, [83:80] found_slot,
   // [88:84] entry_count, [95:89] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [STATUS_W-1:0]    rsp_tuser
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int WORD_W = IP_W + PAYLOAD_BITS;

   logic              res_valid;
   logic              res_ready;
   arpc_result_type   res;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   logic              rsp_valid_ff;
   arpc_result_type   rsp_ff;

   arpc_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser),
      .req_ip     (req_tdata[31:0]),
      .req_data   (req_tdata[79:32]),
      .req_slot   (req_tdata[83:80]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   arpc_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Output register: load when empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {7'd0, rsp_ff.entry_count, rsp_ff.found_slot,
                        rsp_ff.found_data, rsp_ff.found_ip};

endmodule

/* hdl/arpc_checker.sv */
// Port-level checks for the ARP cache table, bound to the top level.
// Depends on arpc_pkg for field widths and status codes.
module arpc_checker
   import arpc_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Any failure carries no entry contents and no slot.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |->
         rsp_tdata[83:0] == '0)
      else $error("failed item carries entry fields");

   // Full is only reported with the table at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |->
         TABLE_DEPTH >= 32 || rsp_tdata[88:84] == 5'(TABLE_DEPTH))
      else $error("full reported below capacity");

   // Count never exceeds the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> TABLE_DEPTH >= 32 || rsp_tdata[88:84] <= 5'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

endmodule

bind arp_cache_table_top arpc_checker #(
   .TABLE_DEPTH(TABLE_DEPTH)
) u_arpc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

/* dv/tb_arp_cache_table_top.sv */
// Self-checking testbench for arp_cache_table_top: insert, lookup, read and
// delete items against a cycle-free table predictor, stream bus on both sides.
// Depends on arpc_pkg and the arp_cache_table_top RTL.
module tb_arp_cache_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import arpc_pkg::*;

   localparam int DEPTH        = 16;
   localparam int KEY_POOL     = 24;
   localparam int RANDOM_OPS   = 1100;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int SHOW_LIMIT   = 10;

   typedef struct packed {
      arpc_mode_type       mode;
      logic [IP_W-1:0]     ip_addr;
      logic [DATA_W-1:0]   entry_data;
      logic [SLOT_W-1:0]   slot;
      logic [1:0]          idle_phase;
      logic                wait_empty;
   } cache_op_type;

   typedef struct packed {
      logic [DEPTH-1:0][IP_W-1:0]   keys;
      logic [DEPTH-1:0][DATA_W-1:0] payloads;
      logic [COUNT_W-1:0]           count;
   } cache_image_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]      req_tuser  = MODE_INSERT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   cache_op_type    op_queue[$];
   arpc_result_type result_queue[$];
   cache_image_type plan_image;
   cache_image_type table_image;
   cache_op_type    active_op;
   logic [1:0]      traffic_phase = 2'd0;

   int send_gap_pct [3] = '{11, 74, 0};
   int recv_gap_pct [3] = '{74, 11, 0};

   int ops_accepted   = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int hold_left      = 0;
   int holds_done     = 0;
   int peak_count     = 0;
   int stall_cycles   = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   arp_cache_table_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Apply one operation to a table image and return the result it produces.
   function automatic arpc_result_type cache_apply(inout cache_image_type img,
                                                   input cache_op_type op);
      arpc_result_type res;
      int hit;
      res = '0;
      res.status = ST_OK;
      hit = -1;
      // scan from the top so the lowest matching slot wins
      for (int i = DEPTH - 1; i >= 0; i--)
         if (i < img.count && img.keys[i] == op.ip_addr) hit = i;
      case (op.mode)
         MODE_INSERT: begin
            if (hit >= 0) begin
               img.payloads[hit] = op.entry_data;
               res.found_slot = SLOT_W'(hit);
            end else if (img.count < DEPTH) begin
               img.keys[img.count] = op.ip_addr;
               img.payloads[img.count] = op.entry_data;
               res.found_slot = img.count[SLOT_W-1:0];
               img.count = img.count + 1'b1;
            end else begin
               res.status = ST_FULL;
            end
         end
         MODE_LOOKUP: begin
            if (hit >= 0) begin
               res.found_ip   = img.keys[hit];
               res.found_data = img.payloads[hit];
               res.found_slot = SLOT_W'(hit);
            end else begin
               res.status = ST_MISS;
            end
         end
         MODE_READ: begin
            if (op.slot < img.count) begin
               res.found_ip   = img.keys[op.slot];
               res.found_data = img.payloads[op.slot];
               res.found_slot = op.slot;
            end else begin
               res.status = ST_RANGE;
            end
         end
         default: begin
            if (op.slot < img.count) begin
               // close the gap: later entries move down one slot
               for (int i = 0; i < DEPTH - 1; i++)
                  if (i >= op.slot && i + 1 < img.count) begin
                     img.keys[i]     = img.keys[i + 1];
                     img.payloads[i] = img.payloads[i + 1];
                  end
               img.count = img.count - 1'b1;
               res.found_slot = op.slot;
            end else begin
               res.status = ST_RANGE;
            end
         end
      endcase
      res.entry_count = img.count;
      return res;
   endfunction

   task automatic queue_op(input arpc_mode_type mode, input logic [IP_W-1:0] ip,
                           input logic [DATA_W-1:0] data, input logic [SLOT_W-1:0] slot,
                           input logic [1:0] phase, input logic hold_for_empty);
      cache_op_type op;
      op.mode       = mode;
      op.ip_addr    = ip;
      op.entry_data = data;
      op.slot       = slot;
      op.idle_phase = phase;
      op.wait_empty = hold_for_empty;
      // track the table while planning so random items can aim at live entries
      void'(cache_apply(plan_image, op));
      op_queue.push_back(op);
   endtask

   function automatic void note_mismatch(string what, arpc_result_type want,
                                         arpc_result_type got);
      mismatch_count++;
      if (mismatch_count <= SHOW_LIMIT)
         $display({"[%0t] %s: expected st=%s ip=%h data=%h slot=%0d cnt=%0d,",
                   " got st=%s ip=%h data=%h slot=%0d cnt=%0d"},
                  $realtime, what, want.status.name(), want.found_ip, want.found_data,
                  want.found_slot, want.entry_count, got.status.name(), got.found_ip,
                  got.found_data, got.found_slot, got.entry_count);
   endfunction

   // Request driver: pops planned items, predicts each one on acceptance.
   always @(posedge clock) begin : req_driver
      cache_op_type nxt;
      logic took;
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         took = req_tvalid && req_tready;
         if (took) begin
            result_queue.push_back(cache_apply(table_image, active_op));
            ops_accepted++;
            if (table_image.count > peak_count) peak_count = table_image.count;
         end
         offer = req_tvalid && !took;
         if (!offer && op_queue.size() != 0) begin
            nxt = op_queue[0];
            if (!(nxt.wait_empty && result_queue.size() != 0) &&
                $urandom_range(99) >= send_gap_pct[nxt.idle_phase]) begin
               nxt = op_queue.pop_front();
               active_op = nxt;
               req_tdata <= {4'b0, nxt.slot, nxt.entry_data, nxt.ip_addr};
               req_tuser <= nxt.mode;
               traffic_phase <= nxt.idle_phase;
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // Response monitor: checks each result and drives backpressure.
   always @(posedge clock) begin : rsp_monitor
      arpc_result_type want;
      arpc_result_type got;
      logic ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = arpc_status_type'(rsp_tuser);
            got.found_ip    = rsp_tdata[31:0];
            got.found_data  = rsp_tdata[79:32];
            got.found_slot  = rsp_tdata[83:80];
            got.entry_count = rsp_tdata[88:84];
            results_seen++;
            status_seen[got.status]++;
            if (result_queue.size() == 0) begin
               note_mismatch("unexpected item", '0, got);
            end else begin
               want = result_queue.pop_front();
               if (got !== want) note_mismatch("mismatch", want, got);
            end
            // hold off for a long stretch now and then so the block backs up
            if (results_seen % 400 == 200) begin
               hold_left = HOLD_CYCLES;
               holds_done++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = $urandom_range(99) >= recv_gap_pct[traffic_phase];
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles, %0d of %0d results checked",
                  STALL_LIMIT, results_seen, ops_accepted);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : main_seq
      logic [IP_W-1:0]    key_pool [KEY_POOL];
      logic [IP_W-1:0]    base;
      logic [IP_W-1:0]    key;
      logic [SLOT_W-1:0]  slot;
      logic [1:0]         phase;
      arpc_mode_type      mode;
      logic               filling;
      int                 pick;
      int                 top;
      int                 total_ops;

      plan_image  = '0;
      table_image = '0;

      // keys in groups of four, each differing from a shared base in a single byte
      base = '0;
      for (int p = 0; p < KEY_POOL; p++) begin
         if (p % 4 == 0) base = $urandom;
         key_pool[p] = base ^ (32'($urandom_range(1, 255)) << (8 * (p % 4)));
      end

      // directed: empty table, extreme keys and payloads, update, full, deletes
      queue_op(MODE_READ,   '0, '0, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_DELETE, '1, '1, 4'd15, 2'd0, 1'b0);
      queue_op(MODE_LOOKUP, '0, '0, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_INSERT, '0, '0, 4'd15, 2'd0, 1'b0);
      queue_op(MODE_INSERT, '1, '1, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_LOOKUP, '1, '0, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_INSERT, '0, 48'hA5A5_5A5A_A5A5, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_LOOKUP, 32'h00FF_FFFF, '0, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_READ,   '0, '0, 4'd1, 2'd0, 1'b0);
      for (int i = 0; i < DEPTH - 2; i++)
         queue_op(MODE_INSERT, 32'h0A00_0000 | i, {16'($urandom), 32'($urandom)},
                  4'd0, 2'd0, 1'b0);
      queue_op(MODE_INSERT, 32'hC0A8_0001, '1, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_INSERT, '1, 48'h0123_4567_89AB, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_DELETE, '0, '0, 4'd0, 2'd0, 1'b0);
      queue_op(MODE_DELETE, '0, '0, 4'd14, 2'd0, 1'b0);
      queue_op(MODE_DELETE, '0, '0, 4'd15, 2'd0, 1'b0);

      // random: alternate fill-heavy and drain-heavy stretches
      filling = 1'b0;
      for (int k = 0; k < RANDOM_OPS; k++) begin
         if (k % 120 == 0) filling = !filling;
         phase = (k < RANDOM_OPS / 3) ? 2'd0 : (k < 2 * RANDOM_OPS / 3) ? 2'd1 : 2'd2;
         pick = $urandom_range(99);
         if (filling) begin
            if (pick < 50)      mode = MODE_INSERT;
            else if (pick < 70) mode = MODE_LOOKUP;
            else if (pick < 88) mode = MODE_READ;
            else                mode = MODE_DELETE;
         end else begin
            if (pick < 15)      mode = MODE_INSERT;
            else if (pick < 40) mode = MODE_LOOKUP;
            else if (pick < 60) mode = MODE_READ;
            else                mode = MODE_DELETE;
         end
         key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                       : IP_W'($urandom);
         if (mode == MODE_LOOKUP && plan_image.count != 0 && $urandom_range(1) == 1)
            key = plan_image.keys[$urandom_range(plan_image.count - 1)];
         top = (plan_image.count > DEPTH - 1) ? DEPTH - 1 : plan_image.count;
         slot = ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(15))
                                         : SLOT_W'($urandom_range(top));
         queue_op(mode, key, {16'($urandom), 32'($urandom)}, slot, phase,
                  (k == RANDOM_OPS / 3) || (k == 2 * RANDOM_OPS / 3) || (k % 300 == 150));
      end
      total_ops = op_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (ops_accepted < total_ops || result_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d table ops over fill and drain stretches, %0d results checked,",
               ops_accepted, results_seen);
      $display("peak occupancy %0d, status mix ok=%0d full=%0d miss=%0d range=%0d,",
               peak_count, status_seen[ST_OK], status_seen[ST_FULL],
               status_seen[ST_MISS], status_seen[ST_RANGE]);
      $display("%0d long output stalls, %0d mismatches", holds_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* arp_cache_table_top.f */
hdl/arpc_pkg.sv
hdl/arpc_ram.sv
hdl/arpc_ctrl.sv
hdl/arp_cache_table_top.sv
hdl/arpc_checker.sv
dv/tb_arp_cache_table_top.sv
